>>> src/lja_pkg.sv
package lja_pkg;

    localparam int ID_W       = 13;
    localparam int POS_W      = 24;
    localparam int DIFF_W     = POS_W + 1;
    localparam int F_W        = 40;
    localparam int EPS_W      = 24;
    localparam int SIG_W      = 24;
    localparam int DIST_W     = 32;
    localparam int R2_W       = 50;
    localparam int DIV_W      = 64;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam int MAX_PARTICLES_DEF = 8192;

    localparam logic [EPS_W-1:0]  EPSILON_RST  = 24'd65536;
    localparam logic [SIG_W-1:0]  SIGMA_SQ_RST = 24'd65536;
    localparam logic [DIST_W-1:0] CUTOFF_RST   = 32'd409600;
    localparam logic [DIST_W-1:0] MIN_DIST_RST = 32'd32768;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA_SQ = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 8'd3;

    // item opcodes
    localparam logic OPC_PAIR = 1'b0;
    localparam logic OPC_READ = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_SQ,
        OP_CHK,
        OP_S2,
        OP_S4,
        OP_S6,
        OP_H,
        OP_HE,
        OP_KS,
        OP_K,
        OP_CLO,
        OP_CHI,
        OP_CFIN,
        OP_RD_A,
        OP_WR_A,
        OP_WR_B,
        OP_RD_CLR,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] axis;
    } lja_cmd_t;

    typedef struct packed {
        logic pair_ok;
        logic div_done;
        logic clear_last;
        logic out_free;
    } lja_status_t;

endpackage

>>> src/lja_if.sv
interface lja_in_if import lja_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [ID_W-1:0]         id_a;
    logic [ID_W-1:0]         id_b;
    logic signed [POS_W-1:0] pos_ax;
    logic signed [POS_W-1:0] pos_ay;
    logic signed [POS_W-1:0] pos_az;
    logic signed [POS_W-1:0] pos_bx;
    logic signed [POS_W-1:0] pos_by;
    logic signed [POS_W-1:0] pos_bz;

    modport source (output valid, op, id_a, id_b, pos_ax, pos_ay, pos_az,
                    pos_bx, pos_by, pos_bz, input ready);
    modport sink (input valid, op, id_a, id_b, pos_ax, pos_ay, pos_az,
                  pos_bx, pos_by, pos_bz, output ready);
endinterface

interface lja_out_if import lja_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ID_W-1:0]       particle;
    logic signed [F_W-1:0] force_x;
    logic signed [F_W-1:0] force_y;
    logic signed [F_W-1:0] force_z;
    logic                  interacting;
    logic                  saturated;

    modport source (output valid, particle, force_x, force_y, force_z,
                    interacting, saturated, input ready);
    modport sink (input valid, particle, force_x, force_y, force_z,
                  interacting, saturated, output ready);
endinterface

interface lja_cfg_if import lja_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> src/lja_div.sv
module lja_div import lja_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] num,
    input  logic [R2_W-1:0]  den,
    output logic             done,
    output logic [DIV_W-1:0] quot
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [R2_W-1:0]  rem_reg, rem_next;
    logic [R2_W-1:0]  den_reg, den_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [R2_W:0]    trial;

    // restoring division, one quotient bit per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            rem_next  = '0;
            den_next  = den;
            quo_next  = num;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = R2_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[R2_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

>>> src/lja_dp.sv
module lja_dp import lja_pkg::*; #(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  lja_cmd_t    cmd,
    output lja_status_t sts,
    lja_in_if.sink      pair_in,
    lja_out_if.source   result,
    lja_cfg_if.sink     cfg
);

    localparam int AW = $clog2(MAX_PARTICLES);

    localparam logic [DIV_W-1:0] S_CAP = 64'h7FFF_FFFF;
    localparam logic [DIV_W-1:0] K_CAP = 64'h3F_FFFF_FFFF;
    localparam logic [31:0]      ONE_Q24 = 32'h0100_0000;
    localparam logic signed [F_W+1:0] F_MAX42 = 42'sh07F_FFFF_FFFF;
    localparam logic signed [F_W+1:0] F_MIN42 = 42'sh380_0000_0000;
    localparam logic [F_W-1:0] F_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [F_W-1:0] F_MIN = 40'h80_0000_0000;

    function automatic logic [31:0] cap31(input logic [DIV_W-1:0] v);
        if (v > S_CAP) return {1'b1, 31'h7FFF_FFFF};
        return {1'b0, v[30:0]};
    endfunction

    // {clamped, value}
    function automatic logic [F_W:0] sat40(input logic signed [F_W+1:0] v);
        if (v > F_MAX42) return {1'b1, F_MAX};
        if (v < F_MIN42) return {1'b1, F_MIN};
        return {1'b0, v[F_W-1:0]};
    endfunction

    // configuration
    logic [EPS_W-1:0]  eps_reg;
    logic [SIG_W-1:0]  sig_reg;
    logic [DIST_W-1:0] cut_reg;
    logic [DIST_W-1:0] min_reg;

    // item state
    logic                     opc_reg, opc_next;
    logic [ID_W-1:0]          ia_reg, ia_next;
    logic [ID_W-1:0]          ib_reg, ib_next;
    logic signed [DIFF_W-1:0] r_reg [3];
    logic signed [DIFF_W-1:0] r_next [3];
    logic [R2_W-1:0]          r2_reg, r2_next;
    logic [30:0]              s2_reg, s2_next;
    logic [30:0]              s4_reg, s4_next;
    logic [30:0]              s6_reg, s6_next;
    logic [30:0]              h_reg, h_next;
    logic                     hneg_reg, hneg_next;
    logic [54:0]              pe_reg, pe_next;
    logic [37:0]              k_reg, k_next;
    logic [DIV_W-1:0]         acc_reg, acc_next;
    logic signed [F_W-1:0]    f_reg [3];
    logic signed [F_W-1:0]    f_next [3];
    logic                     inter_reg, inter_next;
    logic                     sat_reg, sat_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [ID_W-1:0]       out_id_reg;
    logic signed [F_W-1:0] out_f_reg [3];
    logic                  out_inter_reg;
    logic                  out_sat_reg;

    // clearing pass
    logic [AW-1:0] clr_reg, clr_next;

    // accumulator memories
    logic signed [F_W-1:0] mem_x [MAX_PARTICLES];
    logic signed [F_W-1:0] mem_y [MAX_PARTICLES];
    logic signed [F_W-1:0] mem_z [MAX_PARTICLES];
    logic signed [F_W-1:0] rd_reg [3];
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic signed [F_W-1:0] mem_wd [3];

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    logic               div_start;
    logic [DIV_W-1:0]   div_num;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;

    logic                 ia_ok, ib_ok;
    logic [ID_W+AW-1:0]   ia_ext, ib_ext;
    logic [AW-1:0]        ia_addr, ib_addr;
    logic signed [DIFF_W-1:0] r_sel;
    logic [DIFF_W-1:0]    r_abs;
    logic [31:0]          cap_v;
    logic [31:0]          two_s6;
    logic [31:0]          h_diff;
    logic [51:0]          m_val;
    logic                 f_neg;
    logic [F_W:0]         sat_v [3];

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign ia_ext  = {{AW{1'b0}}, ia_reg};
    assign ib_ext  = {{AW{1'b0}}, ib_reg};
    assign ia_addr = ia_ext[AW-1:0];
    assign ib_addr = ib_ext[AW-1:0];
    assign ia_ok   = 32'(ia_reg) < MAX_PARTICLES;
    assign ib_ok   = 32'(ib_reg) < MAX_PARTICLES;

    assign r_sel = r_reg[cmd.axis];
    assign r_abs = r_sel[DIFF_W-1] ? DIFF_W'(-r_sel) : DIFF_W'(r_sel);

    assign sts.pair_ok = (ib_reg > ia_reg) && ia_ok && ib_ok
                         && (r2_reg < R2_W'({cut_reg, 8'b0}))
                         && (r2_reg > R2_W'({min_reg, 8'b0}))
                         && (r2_reg != '0);
    assign sts.div_done   = div_done;
    assign sts.clear_last = (clr_reg == AW'(MAX_PARTICLES - 1));
    assign sts.out_free   = !out_valid_reg || result.ready;

    assign div_start = ((cmd.op == OP_CHK) && sts.pair_ok) || (cmd.op == OP_KS);
    assign div_num   = (cmd.op == OP_KS) ? ((64'(pe_reg) << 4) + (64'(pe_reg) << 3))
                                         : {8'b0, sig_reg, 32'b0};

    lja_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (r2_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb begin
        opc_next   = opc_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        r_next     = r_reg;
        r2_next    = r2_reg;
        s2_next    = s2_reg;
        s4_next    = s4_reg;
        s6_next    = s6_reg;
        h_next     = h_reg;
        hneg_next  = hneg_reg;
        pe_next    = pe_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        f_next     = f_reg;
        inter_next = inter_reg;
        sat_next   = sat_reg;
        clr_next   = clr_reg;
        out_valid_next = out_valid_reg && !result.ready;
        mul_a      = '0;
        mul_b      = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = ia_addr;
        mem_raddr  = ia_addr;
        mem_wd     = '{'0, '0, '0};
        cap_v      = '0;
        two_s6     = {s6_reg, 1'b0};
        h_diff     = '0;
        m_val      = acc_reg[DIV_W-1:12];
        f_neg      = hneg_reg ^ r_sel[DIFF_W-1];
        for (int i = 0; i < 3; i++) begin
            sat_v[i] = '0;
        end
        unique case (cmd.op)
            OP_NONE: ;
            OP_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
            end
            OP_LOAD: begin
                opc_next  = pair_in.op;
                ia_next   = pair_in.id_a;
                ib_next   = pair_in.id_b;
                r_next[0] = DIFF_W'(pair_in.pos_bx) - DIFF_W'(pair_in.pos_ax);
                r_next[1] = DIFF_W'(pair_in.pos_by) - DIFF_W'(pair_in.pos_ay);
                r_next[2] = DIFF_W'(pair_in.pos_bz) - DIFF_W'(pair_in.pos_az);
                r2_next   = '0;
                sat_next  = 1'b0;
                inter_next = 1'b0;
            end
            OP_SQ: begin
                mul_a   = 32'(r_abs);
                mul_b   = 32'(r_abs);
                r2_next = r2_reg + mul_p[R2_W-1:0];
            end
            OP_CHK: begin
                if (sts.pair_ok) begin
                    inter_next = 1'b1;
                end else begin
                    f_next     = '{'0, '0, '0};
                    inter_next = 1'b0;
                    sat_next   = 1'b0;
                end
            end
            OP_S2: begin
                cap_v    = cap31(div_quot);
                s2_next  = cap_v[30:0];
                sat_next = sat_reg | cap_v[31];
            end
            OP_S4: begin
                mul_a    = {1'b0, s2_reg};
                mul_b    = {1'b0, s2_reg};
                cap_v    = cap31(mul_p >> 24);
                s4_next  = cap_v[30:0];
                sat_next = sat_reg | cap_v[31];
            end
            OP_S6: begin
                mul_a    = {1'b0, s4_reg};
                mul_b    = {1'b0, s2_reg};
                cap_v    = cap31(mul_p >> 24);
                s6_next  = cap_v[30:0];
                sat_next = sat_reg | cap_v[31];
            end
            OP_H: begin
                // s6*(1-2*s6) kept as sign and magnitude
                if (two_s6 <= ONE_Q24) begin
                    hneg_next = 1'b0;
                    h_diff    = ONE_Q24 - two_s6;
                end else begin
                    hneg_next = 1'b1;
                    h_diff    = two_s6 - ONE_Q24;
                end
                mul_a    = {1'b0, s6_reg};
                mul_b    = h_diff;
                cap_v    = cap31(mul_p >> 24);
                h_next   = cap_v[30:0];
                sat_next = sat_reg | cap_v[31];
            end
            OP_HE: begin
                mul_a   = {1'b0, h_reg};
                mul_b   = {8'b0, eps_reg};
                pe_next = mul_p[54:0];
            end
            OP_KS: ;
            OP_K: begin
                if (div_quot > K_CAP) begin
                    k_next   = K_CAP[37:0];
                    sat_next = 1'b1;
                end else begin
                    k_next = div_quot[37:0];
                end
            end
            OP_CLO: begin
                mul_a    = 32'(r_abs);
                mul_b    = {13'b0, k_reg[18:0]};
                acc_next = mul_p;
            end
            OP_CHI: begin
                mul_a    = 32'(r_abs);
                mul_b    = {13'b0, k_reg[37:19]};
                acc_next = acc_reg + (mul_p << 19);
            end
            OP_CFIN: begin
                if (!f_neg) begin
                    if (m_val > 52'(F_MAX)) begin
                        f_next[cmd.axis] = F_MAX;
                        sat_next = 1'b1;
                    end else begin
                        f_next[cmd.axis] = m_val[F_W-1:0];
                    end
                end else begin
                    if (m_val > 52'(F_MIN)) begin
                        f_next[cmd.axis] = F_MIN;
                        sat_next = 1'b1;
                    end else begin
                        f_next[cmd.axis] = F_W'(0) - m_val[F_W-1:0];
                    end
                end
            end
            OP_RD_A: begin
                mem_re    = 1'b1;
                mem_raddr = ia_addr;
            end
            OP_WR_A: begin
                for (int i = 0; i < 3; i++) begin
                    sat_v[i]  = sat40((F_W+2)'(rd_reg[i]) + (F_W+2)'(f_reg[i]));
                    mem_wd[i] = sat_v[i][F_W-1:0];
                end
                sat_next  = sat_reg | sat_v[0][F_W] | sat_v[1][F_W] | sat_v[2][F_W];
                mem_we    = 1'b1;
                mem_waddr = ia_addr;
                mem_re    = 1'b1;
                mem_raddr = ib_addr;
            end
            OP_WR_B: begin
                for (int i = 0; i < 3; i++) begin
                    sat_v[i]  = sat40((F_W+2)'(rd_reg[i]) - (F_W+2)'(f_reg[i]));
                    mem_wd[i] = sat_v[i][F_W-1:0];
                end
                sat_next  = sat_reg | sat_v[0][F_W] | sat_v[1][F_W] | sat_v[2][F_W];
                mem_we    = 1'b1;
                mem_waddr = ib_addr;
            end
            OP_RD_CLR: begin
                inter_next = 1'b0;
                sat_next   = 1'b0;
                if (ia_ok) begin
                    f_next    = rd_reg;
                    mem_we    = 1'b1;
                    mem_waddr = ia_addr;
                end else begin
                    f_next = '{'0, '0, '0};
                end
            end
            OP_OUT: begin
                out_valid_next = 1'b1;
            end
        endcase
    end

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg       <= EPSILON_RST;
            sig_reg       <= SIGMA_SQ_RST;
            cut_reg       <= CUTOFF_RST;
            min_reg       <= MIN_DIST_RST;
            out_valid_reg <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            clr_reg       <= clr_next;
            if (cfg.valid)
            begin
                if (cfg.index == REG_EPSILON)
                begin
                    eps_reg <= cfg.data[EPS_W-1:0];
                end
                else if (cfg.index == REG_SIGMA_SQ)
                begin
                    sig_reg <= cfg.data[SIG_W-1:0];
                end
                else if (cfg.index == REG_CUTOFF)
                begin
                    cut_reg <= cfg.data;
                end
                else if (cfg.index == REG_MIN_DIST)
                begin
                    min_reg <= cfg.data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        opc_reg   <= opc_next;
        ia_reg    <= ia_next;
        ib_reg    <= ib_next;
        r_reg     <= r_next;
        r2_reg    <= r2_next;
        s2_reg    <= s2_next;
        s4_reg    <= s4_next;
        s6_reg    <= s6_next;
        h_reg     <= h_next;
        hneg_reg  <= hneg_next;
        pe_reg    <= pe_next;
        k_reg     <= k_next;
        acc_reg   <= acc_next;
        f_reg     <= f_next;
        inter_reg <= inter_next;
        sat_reg   <= sat_next;
        if (cmd.op == OP_OUT)
        begin
            out_id_reg    <= ia_reg;
            out_f_reg     <= f_reg;
            out_inter_reg <= inter_reg;
            // a read reports no clamp
            out_sat_reg   <= sat_reg && (opc_reg == OPC_PAIR);
        end
    end

    // accumulator memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_x[mem_waddr] <= mem_wd[0];
            mem_y[mem_waddr] <= mem_wd[1];
            mem_z[mem_waddr] <= mem_wd[2];
        end
        if (mem_re)
        begin
            rd_reg[0] <= mem_x[mem_raddr];
            rd_reg[1] <= mem_y[mem_raddr];
            rd_reg[2] <= mem_z[mem_raddr];
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.particle    = out_id_reg;
    assign result.force_x     = out_f_reg[0];
    assign result.force_y     = out_f_reg[1];
    assign result.force_z     = out_f_reg[2];
    assign result.interacting = out_inter_reg;
    assign result.saturated   = out_sat_reg;

endmodule

>>> src/lja_ctrl.sv
module lja_ctrl import lja_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_op,
    output logic        in_ready,
    input  lja_status_t sts,
    output lja_cmd_t    cmd
);

    typedef enum logic [18:0] {
        S_CLEAR = 19'h00001,
        S_IDLE  = 19'h00002,
        S_SQ    = 19'h00004,
        S_CHK   = 19'h00008,
        S_DIV1  = 19'h00010,
        S_S4    = 19'h00020,
        S_S6    = 19'h00040,
        S_H     = 19'h00080,
        S_HE    = 19'h00100,
        S_KS    = 19'h00200,
        S_DIV2  = 19'h00400,
        S_CLO   = 19'h00800,
        S_CHI   = 19'h01000,
        S_CFIN  = 19'h02000,
        S_RDA   = 19'h04000,
        S_WRA   = 19'h08000,
        S_WRB   = 19'h10000,
        S_RDCLR = 19'h20000,
        S_OUT   = 19'h40000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       read_reg, read_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        read_next  = read_reg;
        cmd.op     = OP_NONE;
        cmd.axis   = axis_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (sts.clear_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (in_valid) begin
                    cmd.op    = OP_LOAD;
                    axis_next = 2'd0;
                    read_next = (in_op == OPC_READ);
                    state_next = (in_op == OPC_READ) ? S_RDA : S_SQ;
                end
            end
            S_SQ: begin
                cmd.op = OP_SQ;
                if (axis_reg == 2'd2) begin
                    axis_next  = 2'd0;
                    state_next = S_CHK;
                end else begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            S_CHK: begin
                cmd.op     = OP_CHK;
                state_next = sts.pair_ok ? S_DIV1 : S_OUT;
            end
            S_DIV1: begin
                if (sts.div_done) begin
                    cmd.op     = OP_S2;
                    state_next = S_S4;
                end
            end
            S_S4: begin
                cmd.op     = OP_S4;
                state_next = S_S6;
            end
            S_S6: begin
                cmd.op     = OP_S6;
                state_next = S_H;
            end
            S_H: begin
                cmd.op     = OP_H;
                state_next = S_HE;
            end
            S_HE: begin
                cmd.op     = OP_HE;
                state_next = S_KS;
            end
            S_KS: begin
                cmd.op     = OP_KS;
                state_next = S_DIV2;
            end
            S_DIV2: begin
                if (sts.div_done) begin
                    cmd.op     = OP_K;
                    state_next = S_CLO;
                end
            end
            S_CLO: begin
                cmd.op     = OP_CLO;
                state_next = S_CHI;
            end
            S_CHI: begin
                cmd.op     = OP_CHI;
                state_next = S_CFIN;
            end
            S_CFIN: begin
                cmd.op = OP_CFIN;
                if (axis_reg == 2'd2) begin
                    axis_next  = 2'd0;
                    state_next = S_RDA;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_CLO;
                end
            end
            S_RDA: begin
                cmd.op     = OP_RD_A;
                state_next = read_reg ? S_RDCLR : S_WRA;
            end
            S_WRA: begin
                cmd.op     = OP_WR_A;
                state_next = S_WRB;
            end
            S_WRB: begin
                cmd.op     = OP_WR_B;
                state_next = S_OUT;
            end
            S_RDCLR: begin
                cmd.op     = OP_RD_CLR;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            axis_reg  <= 2'd0;
            read_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            read_reg  <= read_next;
        end
    end

endmodule

>>> src/lennard_jones_force_accumulator.sv
// channel   direction  contents
// pair_in   in         op, id_a, id_b, pos_ax..pos_bz
// result    out        particle, force_x/y/z, interacting, saturated
// cfg       in         index, data (epsilon, sigma_sq, cutoff_sq, min_dist_sq)
//
// a pair that interacts spends most of its time in the two 64-step restoring
// divisions by r2 on the shared divider. after reset a clearing pass writes
// zero to every accumulator entry while pair_in is not ready. one item at a
// time; the next item is taken while a result waits in the output register,
// and a stalled result holds the block before the next item's output.
module lennard_jones_force_accumulator import lja_pkg::*; #(
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lja_in_if.sink    pair_in,
    lja_out_if.source result,
    lja_cfg_if.sink   cfg
);

    lja_cmd_t    cmd;
    lja_status_t sts;
    logic        in_ready;

    assign pair_in.ready = in_ready;

    lja_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pair_in.valid),
        .in_op    (pair_in.op),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lja_dp #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .pair_in (pair_in),
        .result  (result),
        .cfg     (cfg)
    );

endmodule

>>> tb/lja_tb_if.sv
`timescale 1ns / 100ps

// no extra interfaces needed beyond the RTL ones; this file holds the item and result structs
package lja_tb_pkg;
    import lja_pkg::*;

    typedef struct {
        logic                    op;
        logic [ID_W-1:0]         id_a;
        logic [ID_W-1:0]         id_b;
        logic signed [POS_W-1:0] ax, ay, az, bx, by, bz;
    } pair_item_t;

    typedef struct {
        logic [ID_W-1:0]       particle;
        logic signed [F_W-1:0] fx, fy, fz;
        logic                  interacting;
        logic                  saturated;
    } force_result_t;
endpackage

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import lja_pkg::*;
    import lja_tb_pkg::*;

    localparam longint FMAX = 64'sd549755813887;
    localparam longint FMIN = -64'sd549755813888;
    localparam logic [63:0] SCAP = 64'h7FFFFFFF;
    localparam logic [63:0] KCAP = 64'h3FFFFFFFFF;
    localparam logic [63:0] ONE24 = 64'h1000000;

    // an index outside the register list, written to check it is ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd77;

    logic clk;
    logic rst_n;

    lja_in_if  pair_in ();
    lja_out_if result ();
    lja_cfg_if cfg ();

    lennard_jones_force_accumulator DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pair_in (pair_in),
        .result  (result),
        .cfg     (cfg)
    );

    // predictor state
    logic [EPS_W-1:0]  m_eps;
    logic [SIG_W-1:0]  m_sig;
    logic [DIST_W-1:0] m_cut;
    logic [DIST_W-1:0] m_min;
    longint acc_x [MAX_PARTICLES_DEF];
    longint acc_y [MAX_PARTICLES_DEF];
    longint acc_z [MAX_PARTICLES_DEF];

    pair_item_t    pending_items[$];
    force_result_t expected_forces[$];

    int  mismatches;
    int  accepted_items;
    int  checked_results;
    int  interact_count;
    int  sat_count;
    int  src_idle_pct;
    int  snk_idle_pct;
    bit  driving_done;

    function automatic void queue_item(pair_item_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic logic [63:0] clamp_u(logic [63:0] v, logic [63:0] cap, ref bit sat);
        if (v > cap)
        begin
            sat = 1;
            return cap;
        end
        return v;
    endfunction

    function automatic longint clamp40(longint v, ref bit sat);
        if (v > FMAX)
        begin
            sat = 1;
            return FMAX;
        end
        if (v < FMIN)
        begin
            sat = 1;
            return FMIN;
        end
        return v;
    endfunction

    function automatic longint axis_force(longint r, logic [63:0] k, bit kneg, ref bit sat);
        logic [63:0] ra;
        longint m;
        bit neg;
        ra = (r < 0) ? -r : r;
        m = longint'((ra * k) >> 12);
        neg = kneg != (r < 0);
        return clamp40(neg ? -m : m, sat);
    endfunction

    function automatic force_result_t predict_force(pair_item_t it);
        force_result_t res;
        longint rx, ry, rz;
        logic [63:0] r2, s2, s4, s6, mag, h, k;
        bit hneg, sat;
        longint fx, fy, fz;
        int ia, ib;
        sat = 0;
        ia = int'(it.id_a);
        ib = int'(it.id_b);
        res.particle = it.id_a;
        res.fx = '0;
        res.fy = '0;
        res.fz = '0;
        res.interacting = 0;
        res.saturated = 0;
        if (it.op == OPC_READ)
        begin
            res.fx = F_W'(acc_x[ia]);
            res.fy = F_W'(acc_y[ia]);
            res.fz = F_W'(acc_z[ia]);
            acc_x[ia] = 0;
            acc_y[ia] = 0;
            acc_z[ia] = 0;
            return res;
        end
        rx = longint'(it.bx) - longint'(it.ax);
        ry = longint'(it.by) - longint'(it.ay);
        rz = longint'(it.bz) - longint'(it.az);
        r2 = rx * rx + ry * ry + rz * rz;
        if (ib <= ia || !(r2 < ({32'd0, m_cut} << 8)) ||
            !(r2 > ({32'd0, m_min} << 8)) || r2 == 0)
            return res;
        s2 = clamp_u(({40'd0, m_sig} << 32) / r2, SCAP, sat);
        s4 = clamp_u((s2 * s2) >> 24, SCAP, sat);
        s6 = clamp_u((s4 * s2) >> 24, SCAP, sat);
        if (2 * s6 <= ONE24)
        begin
            hneg = 0;
            mag = s6 * (ONE24 - 2 * s6);
        end
        else
        begin
            hneg = 1;
            mag = s6 * (2 * s6 - ONE24);
        end
        h = clamp_u(mag >> 24, SCAP, sat);
        k = clamp_u((h * 24 * {40'd0, m_eps}) / r2, KCAP, sat);
        fx = axis_force(rx, k, hneg, sat);
        fy = axis_force(ry, k, hneg, sat);
        fz = axis_force(rz, k, hneg, sat);
        acc_x[ia] = clamp40(acc_x[ia] + fx, sat);
        acc_y[ia] = clamp40(acc_y[ia] + fy, sat);
        acc_z[ia] = clamp40(acc_z[ia] + fz, sat);
        acc_x[ib] = clamp40(acc_x[ib] - fx, sat);
        acc_y[ib] = clamp40(acc_y[ib] - fy, sat);
        acc_z[ib] = clamp40(acc_z[ib] - fz, sat);
        res.fx = F_W'(fx);
        res.fy = F_W'(fy);
        res.fz = F_W'(fz);
        res.interacting = 1;
        res.saturated = sat;
        return res;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_in.valid <= 0;
        end
        else if (!pair_in.valid || pair_in.ready)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                pair_item_t it;
                it = pending_items.pop_front();
                pair_in.valid  <= 1;
                pair_in.op     <= it.op;
                pair_in.id_a   <= it.id_a;
                pair_in.id_b   <= it.id_b;
                pair_in.pos_ax <= it.ax;
                pair_in.pos_ay <= it.ay;
                pair_in.pos_az <= it.az;
                pair_in.pos_bx <= it.bx;
                pair_in.pos_by <= it.by;
                pair_in.pos_bz <= it.bz;
            end
            else
            begin
                pair_in.valid <= 0;
            end
        end
    end

    // prediction happens at acceptance, in order
    always @(posedge clk)
    begin
        if (rst_n && pair_in.valid && pair_in.ready)
        begin
            pair_item_t it;
            it.op = pair_in.op;
            it.id_a = pair_in.id_a;
            it.id_b = pair_in.id_b;
            it.ax = pair_in.pos_ax;
            it.ay = pair_in.pos_ay;
            it.az = pair_in.pos_az;
            it.bx = pair_in.pos_bx;
            it.by = pair_in.pos_by;
            it.bz = pair_in.pos_bz;
            expected_forces = {expected_forces, predict_force(it)};
            accepted_items++;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 0;
        else
            result.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            force_result_t exp_r;
            checked_results++;
            if (expected_forces.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result for particle %0d", result.particle);
            end
            else
            begin
                exp_r = expected_forces.pop_front();
                if (result.interacting)
                    interact_count++;
                if (result.saturated)
                    sat_count++;
                if (result.particle !== exp_r.particle || result.force_x !== exp_r.fx ||
                    result.force_y !== exp_r.fy || result.force_z !== exp_r.fz ||
                    result.interacting !== exp_r.interacting ||
                    result.saturated !== exp_r.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp id %0d f %0d %0d %0d i%0b s%0b, ",
                                  "got id %0d f %0d %0d %0d i%0b s%0b"},
                                 exp_r.particle, exp_r.fx, exp_r.fy, exp_r.fz,
                                 exp_r.interacting, exp_r.saturated,
                                 result.particle, result.force_x, result.force_y,
                                 result.force_z, result.interacting, result.saturated);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 0;
        case (idx)
            REG_EPSILON:  m_eps = val[EPS_W-1:0];
            REG_SIGMA_SQ: m_sig = val[SIG_W-1:0];
            REG_CUTOFF:   m_cut = val;
            REG_MIN_DIST: m_min = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || pair_in.valid || expected_forces.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic pair_item_t make_pair(int ia, int ib, int ax, int ay, int az,
                                             int bx, int by, int bz);
        pair_item_t it;
        it.op = OPC_PAIR;
        it.id_a = ID_W'(ia);
        it.id_b = ID_W'(ib);
        it.ax = POS_W'(ax);
        it.ay = POS_W'(ay);
        it.az = POS_W'(az);
        it.bx = POS_W'(bx);
        it.by = POS_W'(by);
        it.bz = POS_W'(bz);
        return it;
    endfunction

    function automatic pair_item_t make_read(int ia);
        pair_item_t it;
        it = make_pair(ia, $urandom_range(8191), $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom);
        it.op = OPC_READ;
        return it;
    endfunction

    // mostly pairs at distances near sigma on a small id pool, so sums build up
    function automatic pair_item_t random_item(int spread);
        pair_item_t it;
        int ia, ib, ax, ay, az;
        int sel;
        sel = $urandom_range(99);
        ia = $urandom_range(15);
        ib = ia + 1 + $urandom_range(6);
        if (sel < 15)
            return make_read($urandom_range(22));
        ax = $urandom;
        ay = $urandom;
        az = $urandom;
        ax = ax >>> 9;
        ay = ay >>> 9;
        az = az >>> 9;
        if (sel < 80)
            it = make_pair(ia, ib, ax, ay, az,
                           ax + $signed($urandom_range(2 * spread) - spread),
                           ay + $signed($urandom_range(2 * spread) - spread),
                           az + $signed($urandom_range(2 * spread) - spread));
        else
            it = make_pair($urandom_range(8191), $urandom_range(8191), $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
        if (sel >= 95)
            it.id_b = it.id_a;
        return it;
    endfunction

    task automatic run_phase(int n, int spread);
        for (int i = 0; i < n; i++)
            queue_item(random_item(spread));
        wait_drained();
    endtask

    initial
    begin
        mismatches = 0;
        accepted_items = 0;
        checked_results = 0;
        interact_count = 0;
        sat_count = 0;
        src_idle_pct = 11;
        snk_idle_pct = 50;
        m_eps = EPSILON_RST;
        m_sig = SIGMA_SQ_RST;
        m_cut = CUTOFF_RST;
        m_min = MIN_DIST_RST;
        for (int i = 0; i < MAX_PARTICLES_DEF; i++)
        begin
            acc_x[i] = 0;
            acc_y[i] = 0;
            acc_z[i] = 0;
        end
        cfg.valid = 0;
        cfg.index = '0;
        cfg.data = '0;
        pair_in.valid = 0;
        pair_in.op = 0;
        pair_in.id_a = '0;
        pair_in.id_b = '0;
        pair_in.pos_ax = '0;
        pair_in.pos_ay = '0;
        pair_in.pos_az = '0;
        pair_in.pos_bx = '0;
        pair_in.pos_by = '0;
        pair_in.pos_bz = '0;
        result.ready = 0;
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset settings, sigma about 1.0 (4096 in Q12.12)
        queue_item(make_pair(0, 1, 0, 0, 0, 4096, 0, 0));
        queue_item(make_pair(0, 1, 0, 0, 0, 0, 4800, 0));
        queue_item(make_pair(1, 2, 0, 0, 0, 0, 0, -3600));
        queue_item(make_pair(2, 3, 100, 100, 100, 3000, 3000, 3000));
        queue_item(make_pair(3, 3, 0, 0, 0, 4096, 0, 0));
        queue_item(make_pair(4, 3, 0, 0, 0, 4096, 0, 0));
        queue_item(make_pair(5, 6, 0, 0, 0, 0, 0, 0));
        queue_item(make_pair(5, 6, 0, 0, 0, 20000, 0, 0));
        queue_item(make_pair(5, 6, 0, 0, 0, 2896, 0, 0));
        queue_item(make_pair(8190, 8191, -8388608, 8388607, -8388608,
                             8388607, -8388608, 8388607));
        queue_item(make_pair(8190, 8191, -5000, 0, 0, -1000, 0, 0));
        queue_item(make_pair(8190, 8191, 8388607, -8388608, 8388607,
                             8388607 - 2000, -8388608 + 2000, 8388607));
        queue_item(make_read(0));
        queue_item(make_read(1));
        queue_item(make_read(8191));
        queue_item(make_read(8190));
        queue_item(make_read(0));
        wait_drained();

        // strong interaction to push accumulators into saturation
        write_reg(REG_EPSILON, 32'hFFFFFF);
        write_reg(REG_SIGMA_SQ, 32'hFFFFFF);
        write_reg(REG_CUTOFF, 32'hFFFFFFFF);
        write_reg(REG_MIN_DIST, 32'd0);
        for (int i = 0; i < 8; i++)
            queue_item(make_pair(10, 11, 0, 0, 0, 1 + i, 0, 0));
        for (int i = 0; i < 8; i++)
            queue_item(make_pair(10, 11, 0, 0, 0, 0, -1 - i, 0));
        queue_item(make_read(10));
        queue_item(make_read(11));
        wait_drained();

        write_reg(REG_EPSILON, EPSILON_RST);
        write_reg(REG_SIGMA_SQ, SIGMA_SQ_RST);
        write_reg(REG_CUTOFF, CUTOFF_RST);
        write_reg(REG_MIN_DIST, MIN_DIST_RST);
        write_reg(REG_UNUSED, 32'hDEADBEEF);
        run_phase(180, 8000);

        // sender pauses until every result is in
        wait_drained();
        src_idle_pct = 50;
        snk_idle_pct = 11;
        write_reg(REG_EPSILON, 32'd300000);
        write_reg(REG_SIGMA_SQ, 32'd40000);
        write_reg(REG_CUTOFF, 32'd150000);
        write_reg(REG_MIN_DIST, 32'd1000);
        run_phase(180, 6000);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_reg(REG_EPSILON, 32'd0);
        write_reg(REG_SIGMA_SQ, 32'd0);
        run_phase(40, 8000);
        write_reg(REG_EPSILON, 32'hFFFFFF);
        write_reg(REG_SIGMA_SQ, 32'd2000000);
        write_reg(REG_CUTOFF, 32'h7FFFFFFF);
        write_reg(REG_MIN_DIST, 32'd16384);
        run_phase(150, 30000);
        write_reg(REG_EPSILON, EPSILON_RST);
        write_reg(REG_SIGMA_SQ, SIGMA_SQ_RST);
        write_reg(REG_CUTOFF, CUTOFF_RST);
        write_reg(REG_MIN_DIST, MIN_DIST_RST);
        run_phase(120, 8000);
        for (int i = 0; i < 24; i++)
            queue_item(make_read(i));
        wait_drained();

        $display("items accepted %0d, results checked %0d", accepted_items, checked_results);
        $display("interacting pairs %0d, saturated results %0d, mismatches %0d",
                 interact_count, sat_count, mismatches);
        if (mismatches == 0 && expected_forces.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
